@@ hw/rtl/texture_coordinate_projector_assert.svh @@
// ----------------------------------------------------------------------------
// Texture coordinate projector assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_COORDINATE_PROJECTOR_ASSERT_SVH
`define TEXTURE_COORDINATE_PROJECTOR_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define TCP_ASSERT_SAME(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("texture projector check failed");

// The condition holds in the cycle after the trigger.
`define TCP_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("texture projector check failed");

`endif

@@ hw/rtl/tcp_pkg.sv @@
// ----------------------------------------------------------------------------
// Texture coordinate projector package
// Payload types, register codes, fixed-point constants and the arctangent table.
// ----------------------------------------------------------------------------
package tcp_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int GUARD_BITS  = 6;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  // Working width of the datapath: centred point, guard bits and CORDIC growth.
  localparam int CW          = DIFF_W + GUARD_BITS + 4;
  localparam int PROD_BITS   = 8 + GUARD_BITS + 8;
  localparam int K_SHIFT     = 20;
  localparam logic [19:0] CORDIC_K = 20'd636750;
  localparam int TABLE_LEN   = 24;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    KIND_PLANAR      = 2'd0,
    KIND_CYLINDRICAL = 2'd1,
    KIND_SPHERICAL   = 2'd2,
    KIND_CUBIC       = 2'd3
  } proj_kind_t;

  typedef enum logic [2:0] {
    REG_KIND      = 3'd0,
    REG_AXIS      = 3'd1,
    REG_CENTER    = 3'd2,
    REG_INV_SCALE = 3'd3,
    REG_ROTATION  = 3'd4,
    REG_WRAP_W    = 3'd5,
    REG_WRAP_H    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [15:0]            normal_x;
    logic signed [15:0]            normal_y;
    logic signed [15:0]            normal_z;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0] tex_u;
    logic        [15:0] tex_v;
  } result_t;

  // One classified vertex as it waits between the front and back ends.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [1:0]           plane;
    logic                 flip;
  } fe_entry_t;

  // Arctangent of 2^-i in turns scaled by 2^32.
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/tcp_front.sv @@
// ----------------------------------------------------------------------------
// Texture coordinate projector front end
// Accepts a vertex, centres it and picks the cubic plane and the u sign.
// ----------------------------------------------------------------------------
module tcp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tcp_pkg::in_item_t item,
  input  logic [47:0]       center_xyz,
  input  logic              q_full,
  output logic              push,
  output tcp_pkg::fe_entry_t entry
);
  import tcp_pkg::*;

  logic      fe_vld;
  fe_entry_t fe_q;
  fe_entry_t fe_next;
  logic      load;

  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic signed [16:0]       nx, ny, nz;
  logic        [16:0]       ax, ay, az;

  assign busy  = fe_vld && q_full;
  assign load  = start && !busy;
  assign push  = fe_vld && !q_full;
  assign entry = fe_q;

  // Centre the point, classify the normal for cubic mapping.
  always_comb begin
    dx = DIFF_W'(item.point_x) - DIFF_W'(signed'(center_xyz[15:0]));
    dy = DIFF_W'(item.point_y) - DIFF_W'(signed'(center_xyz[31:16]));
    dz = DIFF_W'(item.point_z) - DIFF_W'(signed'(center_xyz[47:32]));
    nx = 17'(item.normal_x);
    ny = 17'(item.normal_y);
    nz = 17'(item.normal_z);
    ax = nx[16] ? 17'(-nx) : 17'(nx);
    ay = ny[16] ? 17'(-ny) : 17'(ny);
    az = nz[16] ? 17'(-nz) : 17'(nz);
    fe_next.x = {{(CW-DIFF_W-GUARD_BITS){dx[DIFF_W-1]}}, dx, {GUARD_BITS{1'b0}}};
    fe_next.y = {{(CW-DIFF_W-GUARD_BITS){dy[DIFF_W-1]}}, dy, {GUARD_BITS{1'b0}}};
    fe_next.z = {{(CW-DIFF_W-GUARD_BITS){dz[DIFF_W-1]}}, dz, {GUARD_BITS{1'b0}}};
    if (az >= ax && az >= ay) begin
      fe_next.plane = AXIS_Z;
    end else if (ay >= ax && ay >= az) begin
      fe_next.plane = AXIS_Y;
    end else begin
      fe_next.plane = AXIS_X;
    end
    fe_next.flip = (nx > 0) ^ (ny < 0) ^ (nz > 0);
  end

  // Holding register: a new transaction may enter as the old one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      fe_vld <= 1'b0;
    end else if (load) begin
      fe_vld <= 1'b1;
    end else if (!q_full) begin
      fe_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fe_q <= fe_next;
    end
  end

endmodule

@@ hw/rtl/tcp_queue.sv @@
// ----------------------------------------------------------------------------
// Texture coordinate projector queue
// Two-entry queue between the front end and the back-end pipeline.
// ----------------------------------------------------------------------------
module tcp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tcp_pkg::fe_entry_t wr_entry,
  output logic               full,
  output logic               pop,
  output tcp_pkg::fe_entry_t rd_entry
);
  import tcp_pkg::*;

  fe_entry_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  // The back end never stalls, so any stored entry leaves at once.
  assign pop      = (count != 2'd0);
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

endmodule

@@ hw/rtl/tcp_rot.sv @@
// ----------------------------------------------------------------------------
// Texture coordinate projector rotation unit
// Pipelined CORDIC that rotates a coordinate pair by a 16-bit turn angle.
// ----------------------------------------------------------------------------
module tcp_rot #(
  parameter int N  = 16,
  parameter int TW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  logic signed [tcp_pkg::CW-1:0] in_a,
  input  logic signed [tcp_pkg::CW-1:0] in_b,
  input  logic [15:0]               turn,
  input  logic [TW-1:0]             in_tag,
  output logic                      out_vld,
  output logic signed [tcp_pkg::CW-1:0] out_a,
  output logic signed [tcp_pkg::CW-1:0] out_b,
  output logic [TW-1:0]             out_tag
);
  import tcp_pkg::*;

  logic signed [CW-1:0] sa  [N+1];
  logic signed [CW-1:0] sb  [N+1];
  logic signed [31:0]   sz  [N+1];
  logic                 act [N+1];
  logic                 vld [N+1];
  logic [TW-1:0]        tag [N+1];

  logic signed [CW-1:0]  qa, qb;
  logic signed [CW+20:0] pa, pb;

  // Quarter turns are exact swaps and negations.
  always_comb begin
    case (turn[15:14])
      2'd0: begin
        qa = in_a;
        qb = in_b;
      end
      2'd1: begin
        qa = -in_b;
        qb = in_a;
      end
      2'd2: begin
        qa = -in_a;
        qb = -in_b;
      end
      default: begin
        qa = in_b;
        qb = -in_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    sa[0]  <= qa;
    sb[0]  <= qb;
    sz[0]  <= signed'({2'b00, turn[13:0], 16'h0000});
    act[0] <= |turn[13:0];
    tag[0] <= in_tag;
  end

  // One micro-rotation per stage; when the angle is an exact quarter turn, every stage passes through.
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [CW-1:0] dx, dy;
    logic signed [31:0]   at;
    assign dx = sb[i] >>> i;
    assign dy = sa[i] >>> i;
    assign at = signed'(atan_turn(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      act[i+1] <= act[i];
      tag[i+1] <= tag[i];
      if (!act[i]) begin
        sa[i+1] <= sa[i];
        sb[i+1] <= sb[i];
        sz[i+1] <= sz[i];
      end else if (sz[i] >= 0) begin
        sa[i+1] <= sa[i] - dx;
        sb[i+1] <= sb[i] + dy;
        sz[i+1] <= sz[i] - at;
      end else begin
        sa[i+1] <= sa[i] + dx;
        sb[i+1] <= sb[i] - dy;
        sz[i+1] <= sz[i] + at;
      end
    end
  end

  // Remove the CORDIC gain where micro-rotations were applied.
  assign pa = sa[N] * signed'({1'b0, CORDIC_K});
  assign pb = sb[N] * signed'({1'b0, CORDIC_K});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    out_a   <= act[N] ? pa[CW+K_SHIFT-1:K_SHIFT] : sa[N];
    out_b   <= act[N] ? pb[CW+K_SHIFT-1:K_SHIFT] : sb[N];
    out_tag <= tag[N];
  end

endmodule

@@ hw/rtl/tcp_vec.sv @@
// ----------------------------------------------------------------------------
// Texture coordinate projector vectoring unit
// Pipelined CORDIC that gives the angle and length of a coordinate pair.
// ----------------------------------------------------------------------------
module tcp_vec #(
  parameter int N  = 16,
  parameter int TW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  logic signed [tcp_pkg::CW-1:0] in_xc,
  input  logic signed [tcp_pkg::CW-1:0] in_ys,
  input  logic [TW-1:0]             in_tag,
  output logic                      out_vld,
  output logic [31:0]               out_ang,
  output logic signed [tcp_pkg::CW-1:0] out_mag,
  output logic [TW-1:0]             out_tag
);
  import tcp_pkg::*;

  logic signed [CW-1:0] sx   [N+1];
  logic signed [CW-1:0] sy   [N+1];
  logic [31:0]          sang [N+1];
  logic                 spec [N+1];
  logic                 vld  [N+1];
  logic [TW-1:0]        tag  [N+1];

  logic signed [CW-1:0]  x0, y0;
  logic [31:0]           a0;
  logic                  s0;
  logic signed [CW+20:0] px;

  // Axis-aligned and zero vectors are resolved exactly; the rest fold into x > 0.
  always_comb begin
    x0 = in_xc;
    y0 = in_ys;
    a0 = 32'h0000_0000;
    s0 = 1'b1;
    if (in_xc == 0 && in_ys == 0) begin
      x0 = '0;
    end else if (in_ys == 0) begin
      x0 = (in_xc > 0) ? in_xc : -in_xc;
      a0 = (in_xc > 0) ? 32'h0000_0000 : 32'h8000_0000;
    end else if (in_xc == 0) begin
      x0 = (in_ys > 0) ? in_ys : -in_ys;
      a0 = (in_ys > 0) ? 32'h4000_0000 : 32'hC000_0000;
    end else if (in_xc < 0) begin
      x0 = -in_xc;
      y0 = -in_ys;
      a0 = 32'h8000_0000;
      s0 = 1'b0;
    end else begin
      s0 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    sx[0]   <= x0;
    sy[0]   <= y0;
    sang[0] <= a0;
    spec[0] <= s0;
    tag[0]  <= in_tag;
  end

  // One micro-rotation per stage, driving y towards zero.
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [CW-1:0] dx, dy;
    assign dx = sy[i] >>> i;
    assign dy = sx[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      spec[i+1] <= spec[i];
      tag[i+1]  <= tag[i];
      if (spec[i]) begin
        sx[i+1]   <= sx[i];
        sy[i+1]   <= sy[i];
        sang[i+1] <= sang[i];
      end else if (sy[i] > 0) begin
        sx[i+1]   <= sx[i] + dx;
        sy[i+1]   <= sy[i] - dy;
        sang[i+1] <= sang[i] + atan_turn(i);
      end else begin
        sx[i+1]   <= sx[i] - dx;
        sy[i+1]   <= sy[i] + dy;
        sang[i+1] <= sang[i] - atan_turn(i);
      end
    end
  end

  // Gain correction of the length; exact cases keep their length as it is.
  assign px = sx[N] * signed'({1'b0, CORDIC_K});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    out_ang <= sang[N];
    out_mag <= spec[N] ? sx[N] : px[CW+K_SHIFT-1:K_SHIFT];
    out_tag <= tag[N];
  end

endmodule

@@ hw/rtl/texture_coordinate_projector.sv @@
// ----------------------------------------------------------------------------
// Texture coordinate projector
// Centres, rotates and projects a vertex to a (u, v) texture coordinate pair.
// ----------------------------------------------------------------------------
// A vertex is taken whenever start is high and busy is low, one per clock. Its
// (u, v) pair appears on result with result_valid high for a single cycle. The
// front register loads at the accepting edge, and the vertex then passes
// through the queue, three rotation CORDICs and two vectoring CORDICs of
// CORDIC_STAGES + 2 register stages each, the product stage and the result
// register. The result side cannot be held off. The back end never stalls, so
// busy stays low in normal use. The user must write configuration through the
// cfg port only while no vertex is in flight; the block does not enforce this.

`include "texture_coordinate_projector_assert.svh"

module texture_coordinate_projector #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tcp_pkg::in_item_t item,
  output logic              result_valid,
  output tcp_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [47:0]       cfg_data
);
  import tcp_pkg::*;

  localparam int N   = CORDIC_STAGES;
  localparam int TWR = CW + 3;
  localparam int TW1 = 3 * CW + 3;
  localparam int TW2 = 32 + 3 * CW + 3;

  // Configuration registers.
  logic [1:0]  projection_kind;
  logic [1:0]  projection_axis_sel;
  logic [47:0] center_xyz;
  logic [47:0] inv_scale_xyz;
  logic [47:0] rotation_xyz;
  logic [15:0] wrap_width;
  logic [15:0] wrap_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      projection_kind     <= KIND_PLANAR;
      projection_axis_sel <= AXIS_X;
      center_xyz          <= '0;
      inv_scale_xyz       <= 48'h0100_0100_0100;
      rotation_xyz        <= '0;
      wrap_width          <= 16'h0100;
      wrap_height         <= 16'h0100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_KIND:      projection_kind     <= cfg_data[1:0];
        REG_AXIS:      projection_axis_sel <= cfg_data[1:0];
        REG_CENTER:    center_xyz          <= cfg_data;
        REG_INV_SCALE: inv_scale_xyz       <= cfg_data;
        REG_ROTATION:  rotation_xyz        <= cfg_data;
        REG_WRAP_W:    wrap_width          <= cfg_data[15:0];
        REG_WRAP_H:    wrap_height         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Front end and queue.
  logic      q_full, q_push, q_pop;
  fe_entry_t fe_entry, q_entry;

  tcp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .center_xyz (center_xyz),
    .q_full     (q_full),
    .push       (q_push),
    .entry      (fe_entry)
  );

  tcp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (fe_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_entry)
  );

  // Rotation about Y, then Z, then X.
  logic                 r1_vld, r2_vld, r3_vld;
  logic signed [CW-1:0] r1_a, r1_b, r2_a, r2_b, r3_a, r3_b;
  logic [TWR-1:0]       r1_tag, r2_tag, r3_tag;

  tcp_rot #(.N(N), .TW(TWR)) u_rot_y (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (q_pop),
    .in_a    (q_entry.x),
    .in_b    (q_entry.z),
    .turn    (rotation_xyz[31:16]),
    .in_tag  ({q_entry.y, q_entry.plane, q_entry.flip}),
    .out_vld (r1_vld),
    .out_a   (r1_a),
    .out_b   (r1_b),
    .out_tag (r1_tag)
  );

  tcp_rot #(.N(N), .TW(TWR)) u_rot_z (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (r1_vld),
    .in_a    (r1_tag[TWR-1:3]),
    .in_b    (r1_a),
    .turn    (rotation_xyz[47:32]),
    .in_tag  ({r1_b, r1_tag[2:0]}),
    .out_vld (r2_vld),
    .out_a   (r2_a),
    .out_b   (r2_b),
    .out_tag (r2_tag)
  );

  tcp_rot #(.N(N), .TW(TWR)) u_rot_x (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (r2_vld),
    .in_a    (r2_tag[TWR-1:3]),
    .in_b    (r2_a),
    .turn    (rotation_xyz[15:0]),
    .in_tag  ({r2_b, r2_tag[2:0]}),
    .out_vld (r3_vld),
    .out_a   (r3_a),
    .out_b   (r3_b),
    .out_tag (r3_tag)
  );

  // Rotated point: z in a, y in b, x in the tag.
  logic signed [CW-1:0] px, py, pz;
  logic signed [CW-1:0] v1_xc, v1_ys;

  assign px = r3_tag[TWR-1:3];
  assign py = r3_b;
  assign pz = r3_a;

  // Longitude vector for cylindrical and spherical modes.
  always_comb begin
    case (projection_axis_sel)
      AXIS_X: begin
        v1_xc = -py;
        v1_ys = pz;
      end
      AXIS_Y: begin
        v1_xc = pz;
        v1_ys = (projection_kind == KIND_SPHERICAL) ? px : -px;
      end
      default: begin
        v1_xc = -py;
        v1_ys = -px;
      end
    endcase
  end

  logic                 v1_vld, v2_vld;
  logic [31:0]          v1_ang, v2_ang;
  logic signed [CW-1:0] v1_mag, v2_mag;
  logic [TW1-1:0]       v1_tag;
  logic [TW2-1:0]       v2_tag;

  tcp_vec #(.N(N), .TW(TW1)) u_vec_lon (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (r3_vld),
    .in_xc   (v1_xc),
    .in_ys   (v1_ys),
    .in_tag  ({px, py, pz, r3_tag[2:0]}),
    .out_vld (v1_vld),
    .out_ang (v1_ang),
    .out_mag (v1_mag),
    .out_tag (v1_tag)
  );

  // Height coordinate for the latitude vector.
  logic signed [CW-1:0] hx, hy, hz, h;

  assign hx = v1_tag[3*CW+2:2*CW+3];
  assign hy = v1_tag[2*CW+2:CW+3];
  assign hz = v1_tag[CW+2:3];

  always_comb begin
    case (projection_axis_sel)
      AXIS_X:  h = hx;
      AXIS_Y:  h = -hy;
      default: h = hz;
    endcase
  end

  tcp_vec #(.N(N), .TW(TW2)) u_vec_lat (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (v1_vld),
    .in_xc   (v1_mag),
    .in_ys   (h),
    .in_tag  ({v1_ang, v1_tag}),
    .out_vld (v2_vld),
    .out_ang (v2_ang),
    .out_mag (v2_mag),
    .out_tag (v2_tag)
  );

  // Final coordinates and side information.
  logic signed [CW-1:0] fx, fy, fz;
  logic [31:0]          lon, lat;
  logic [1:0]           plane, eff_axis;
  logic                 flip;
  logic [15:0]          isx, isy, isz, isu, isv;
  logic [PROD_BITS-1:0] cu, cv;
  logic [PROD_BITS+15:0] pu_full, pv_full;
  logic [47:0]          wu_full, wv_full;

  assign lon   = v2_tag[TW2-1:TW1];
  assign fx    = v2_tag[3*CW+2:2*CW+3];
  assign fy    = v2_tag[2*CW+2:CW+3];
  assign fz    = v2_tag[CW+2:3];
  assign plane = v2_tag[2:1];
  assign flip  = v2_tag[0];
  assign lat   = 32'h8000_0000 - {v2_ang[30:0], 1'b0};
  assign isx   = inv_scale_xyz[15:0];
  assign isy   = inv_scale_xyz[31:16];
  assign isz   = inv_scale_xyz[47:32];
  assign eff_axis = (projection_kind == KIND_CUBIC) ? plane : projection_axis_sel;

  // Pick the coordinates and scales that feed the linear u and v terms.
  always_comb begin
    if (projection_kind == KIND_CYLINDRICAL) begin
      cu  = fz[PROD_BITS-1:0];
      isu = isz;
      case (projection_axis_sel)
        AXIS_X: begin
          cv  = PROD_BITS'(-fx);
          isv = isx;
        end
        AXIS_Y: begin
          cv  = PROD_BITS'(-fy);
          isv = isy;
        end
        default: begin
          cv  = PROD_BITS'(-fz);
          isv = isz;
        end
      endcase
    end else begin
      case (eff_axis)
        AXIS_X: begin
          cu  = fz[PROD_BITS-1:0];
          isu = isz;
          cv  = fy[PROD_BITS-1:0];
          isv = isy;
        end
        AXIS_Y: begin
          cu  = PROD_BITS'(-fx);
          isu = isx;
          cv  = fz[PROD_BITS-1:0];
          isv = isz;
        end
        default: begin
          cu  = PROD_BITS'(-fx);
          isu = isx;
          cv  = fy[PROD_BITS-1:0];
          isv = isy;
        end
      endcase
    end
  end

  assign pu_full = cu * isu;
  assign pv_full = cv * isv;
  assign wu_full = lon * wrap_width;
  assign wv_full = lat * wrap_height;

  // Product stage.
  logic                 a_vld;
  logic                 a_flip;
  logic [PROD_BITS-1:0] a_su, a_sv;
  logic [15:0]          a_wu, a_wv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= v2_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_su   <= pu_full[PROD_BITS-1:0];
    a_sv   <= pv_full[PROD_BITS-1:0];
    a_wu   <= wu_full[39:24];
    a_wv   <= wv_full[39:24];
    a_flip <= flip;
  end

  // Fraction of the scaled coordinate plus one half, then mode selection.
  logic [PROD_BITS-1:0] su_half, sv_half;
  logic [15:0]          su_frac, sv_frac;
  result_t              result_next;

  assign su_half = a_su + {1'b1, {(PROD_BITS-1){1'b0}}};
  assign sv_half = a_sv + {1'b1, {(PROD_BITS-1){1'b0}}};
  assign su_frac = su_half[PROD_BITS-1:PROD_BITS-16];
  assign sv_frac = sv_half[PROD_BITS-1:PROD_BITS-16];

  always_comb begin
    case (proj_kind_t'(projection_kind))
      KIND_PLANAR: begin
        result_next.tex_u = signed'({1'b0, su_frac});
        result_next.tex_v = sv_frac;
      end
      KIND_CYLINDRICAL: begin
        result_next.tex_u = signed'({1'b0, a_wu});
        result_next.tex_v = sv_frac;
      end
      KIND_SPHERICAL: begin
        result_next.tex_u = signed'({1'b0, a_wu});
        result_next.tex_v = a_wv;
      end
      default: begin
        result_next.tex_u = a_flip ? -signed'({1'b0, su_frac}) : signed'({1'b0, su_frac});
        result_next.tex_v = sv_frac;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // The back end drains every cycle, so the queue never backs up.
  `TCP_ASSERT_SAME(a_never_busy, 1'b1, !busy)
  `TCP_ASSERT_NEXT(a_accept_pushes, start && !busy, q_push)
  `TCP_ASSERT_NEXT(a_kind_write, cfg_valid && cfg_ready && cfg_index == REG_KIND,
                   projection_kind == $past(cfg_data[1:0]))

endmodule

@@ verif/texture_coordinate_projector_tb.sv @@
// ----------------------------------------------------------------------------
// Texture coordinate projector testbench
// Drives vertices through the projector under a range of register settings.
// Each result is checked against a bit-exact fixed-point projection computed
// here. Directed tests cover each mode first, then random phases follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module texture_coordinate_projector_tb;
  import tcp_pkg::*;

  localparam int STAGES     = 16;
  localparam int LATENCY    = 5 * STAGES + 13;
  localparam int STALL_LIM  = 5000;
  localparam int RAND_SETS  = 14;
  localparam int RAND_ITEMS = 100;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_item_t    item;
  logic        result_valid;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  // Shadow copy of the register file.
  logic [1:0]  m_kind;
  logic [1:0]  m_axis;
  logic [47:0] m_center;
  logic [47:0] m_inv_scale;
  logic [47:0] m_rotation;
  logic [15:0] m_wrap_w;
  logic [15:0] m_wrap_h;

  result_t pending_uv[$];
  int      send_idle_pct;
  int      mismatches;
  int      stall_cycles;
  bit      failed;

  texture_coordinate_projector #(.CORDIC_STAGES(STAGES)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint sext16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint gain_corr(longint v);
    return (v * longint'(CORDIC_K)) >>> K_SHIFT;
  endfunction

  // Rotates (a, b) by t / 65536 of a turn.
  task automatic rotate_vec(inout longint a, inout longint b, input logic [15:0] t);
    logic [31:0] ang;
    longint x, y, z, tmp, dx, dy;
    ang = {t, 16'h0000};
    x = a;
    y = b;
    z = longint'(ang[29:0]);
    for (int k = 0; k < ang[31:30]; k++) begin
      tmp = x; x = -y; y = tmp;
    end
    if (z != 0) begin
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_turn(i));
        end else begin
          x += dx; y -= dy; z += longint'(atan_turn(i));
        end
      end
      x = gain_corr(x);
      y = gain_corr(y);
    end
    a = x;
    b = y;
  endtask

  // Angle of (xc, ys) in 32-bit turns, with the vector length.
  task automatic vector_turn(input longint xc_in, input longint ys_in,
                             output logic [31:0] turn, output longint mag);
    logic [63:0] ang;
    longint xc, ys, dx, dy;
    xc = xc_in;
    ys = ys_in;
    ang = 64'd0;
    if (xc == 0 && ys == 0) begin
      mag = 0; turn = 32'h0;
    end else if (ys == 0) begin
      mag = (xc > 0) ? xc : -xc;
      turn = (xc > 0) ? 32'h0 : 32'h8000_0000;
    end else if (xc == 0) begin
      mag = (ys > 0) ? ys : -ys;
      turn = (ys > 0) ? 32'h4000_0000 : 32'hC000_0000;
    end else begin
      if (xc < 0) begin
        xc = -xc; ys = -ys; ang = 64'h8000_0000;
      end
      for (int i = 0; i < STAGES; i++) begin
        dx = ys >>> i;
        dy = xc >>> i;
        if (ys > 0) begin
          xc += dx; ys -= dy; ang += atan_turn(i);
        end else begin
          xc -= dx; ys += dy; ang += 64'h1_0000_0000 - atan_turn(i);
        end
      end
      mag = gain_corr(xc);
      turn = ang[31:0];
    end
  endtask

  function automatic logic [15:0] scaled_frac(longint coord, logic [15:0] inv);
    logic [63:0] p;
    p = coord * longint'(inv) + (64'd1 << (PROD_BITS - 1));
    return p[PROD_BITS-1 -: 16];
  endfunction

  function automatic logic [15:0] wrapped_frac(logic [31:0] turn, logic [15:0] wrap);
    logic [63:0] p;
    p = {32'd0, turn} * {48'd0, wrap};
    return p[39:24];
  endfunction

  task automatic project_uv(input in_item_t it, output result_t uv);
    longint x, y, z, a, c, h, r, dummy, ax, ay, az;
    logic [15:0] isx, isy, isz, f;
    logic [31:0] lon, p, lat, t;
    logic [16:0] u;
    logic [15:0] v;
    int flips;
    logic [1:0] axis;
    isx = m_inv_scale[15:0];
    isy = m_inv_scale[31:16];
    isz = m_inv_scale[47:32];
    axis = m_axis;
    u = '0;
    v = '0;
    x = (sext16(it.point_x) - sext16(m_center[15:0])) <<< GUARD_BITS;
    y = (sext16(it.point_y) - sext16(m_center[31:16])) <<< GUARD_BITS;
    z = (sext16(it.point_z) - sext16(m_center[47:32])) <<< GUARD_BITS;
    if (m_rotation[31:16] != 0) rotate_vec(x, z, m_rotation[31:16]);
    if (m_rotation[47:32] != 0) rotate_vec(y, x, m_rotation[47:32]);
    if (m_rotation[15:0] != 0) rotate_vec(z, y, m_rotation[15:0]);
    case (proj_kind_t'(m_kind))
      KIND_PLANAR: begin
        if (axis == AXIS_X) begin
          u = {1'b0, scaled_frac(z, isz)}; v = scaled_frac(y, isy);
        end else if (axis == AXIS_Y) begin
          u = {1'b0, scaled_frac(-x, isx)}; v = scaled_frac(z, isz);
        end else begin
          u = {1'b0, scaled_frac(-x, isx)}; v = scaled_frac(y, isy);
        end
      end
      KIND_CYLINDRICAL: begin
        if (axis == AXIS_X) begin
          vector_turn(-y, z, t, dummy); v = scaled_frac(-x, isx);
        end else if (axis == AXIS_Y) begin
          vector_turn(z, -x, t, dummy); v = scaled_frac(-y, isy);
        end else begin
          vector_turn(-y, -x, t, dummy); v = scaled_frac(-z, isz);
        end
        u = {1'b0, wrapped_frac(t, m_wrap_w)};
      end
      KIND_SPHERICAL: begin
        if (axis == AXIS_X) begin
          a = z; c = -y; h = x;
        end else if (axis == AXIS_Y) begin
          a = x; c = z; h = -y;
        end else begin
          a = -x; c = -y; h = z;
        end
        vector_turn(c, a, lon, r);
        vector_turn(r, h, p, dummy);
        lat = 32'h8000_0000 - {p[30:0], 1'b0};
        u = {1'b0, wrapped_frac(lon, m_wrap_w)};
        v = wrapped_frac(lat, m_wrap_h);
      end
      default: begin
        ax = sext16(it.normal_x); ay = sext16(it.normal_y); az = sext16(it.normal_z);
        ax = (ax < 0) ? -ax : ax;
        ay = (ay < 0) ? -ay : ay;
        az = (az < 0) ? -az : az;
        // Ties go to Z first, then Y.
        if (az >= ax && az >= ay) begin
          f = scaled_frac(-x, isx); v = scaled_frac(y, isy);
        end else if (ay >= ax && ay >= az) begin
          f = scaled_frac(-x, isx); v = scaled_frac(z, isz);
        end else begin
          f = scaled_frac(z, isz); v = scaled_frac(y, isy);
        end
        flips = 0;
        if (it.normal_x > 0) flips++;
        if (it.normal_y < 0) flips++;
        if (it.normal_z > 0) flips++;
        u = {1'b0, f};
        if (flips % 2 == 1) u = -u;
      end
    endcase
    uv.tex_u = u;
    uv.tex_v = v;
  endtask

  // ----------------------------------------------------------------- checking

  // Each strobed result is compared with the oldest projection waiting.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (pending_uv.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result u=%h v=%h", result.tex_u, result.tex_v);
      end else begin
        want = pending_uv.pop_front();
        if (result.tex_u !== want.tex_u || result.tex_v !== want.tex_v) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: u exp %h got %h, v exp %h got %h",
                     want.tex_u, result.tex_u, want.tex_v, result.tex_v);
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transaction of any kind completes.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIM) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- transport

  task automatic send_vertex(input in_item_t it);
    result_t uv;
    start = 1'b1;
    item = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    project_uv(it, uv);
    pending_uv.push_back(uv);
    @(negedge clk);
    // Each cycle idles with the set probability before the next transaction.
    while ($urandom_range(99) < send_idle_pct) begin
      start = 1'b0;
      item = in_item_t'({$urandom, $urandom, $urandom});
      @(negedge clk);
    end
  endtask

  task automatic drain;
    start = 1'b0;
    wait (pending_uv.size() == 0);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      REG_KIND:      m_kind = data[1:0];
      REG_AXIS:      m_axis = data[1:0];
      REG_CENTER:    m_center = data;
      REG_INV_SCALE: m_inv_scale = data;
      REG_ROTATION:  m_rotation = data;
      REG_WRAP_W:    m_wrap_w = data[15:0];
      REG_WRAP_H:    m_wrap_h = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_item_t vtx(int px, int py, int pz, int nx, int ny, int nz);
    in_item_t it;
    it.point_x = 16'(px); it.point_y = 16'(py); it.point_z = 16'(pz);
    it.normal_x = 16'(nx); it.normal_y = 16'(ny); it.normal_z = 16'(nz);
    return it;
  endfunction

  function automatic in_item_t rand_vertex();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    // Small coordinates and tied normals now and then.
    if ($urandom_range(3) == 0) begin
      it.point_x = 16'($signed($urandom_range(64)) - 32);
      it.point_y = 16'($signed($urandom_range(64)) - 32);
    end
    if ($urandom_range(5) == 0) it.normal_y = $urandom_range(1) ? it.normal_x : -it.normal_x;
    if ($urandom_range(5) == 0) it.normal_z = it.normal_y;
    return it;
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return {2'($urandom_range(3)), 14'h0000};
      default: return 16'($urandom);
    endcase
  endfunction

  // ----------------------------------------------------------------- tests

  task automatic test_planar;
    write_reg(REG_KIND, KIND_PLANAR);
    for (int a = 0; a < 4; a++) begin
      write_reg(REG_AXIS, 48'(a));
      send_vertex(vtx(32767, -32768, 256, 0, 0, 0));
      send_vertex(vtx(-32768, 32767, -1, 0, 0, 0));
    end
  endtask

  task automatic test_cylindrical;
    write_reg(REG_KIND, KIND_CYLINDRICAL);
    write_reg(REG_AXIS, AXIS_Y);
    send_vertex(vtx(0, 0, 0, 0, 0, 0));       // zero vector
    send_vertex(vtx(0, 100, 512, 0, 0, 0));   // axis-aligned
    send_vertex(vtx(-300, 7, 0, 0, 0, 0));
    send_vertex(vtx(1234, -555, -4321, 0, 0, 0));
  endtask

  task automatic test_spherical;
    write_reg(REG_KIND, KIND_SPHERICAL);
    write_reg(REG_WRAP_H, 16'h0200);
    write_reg(REG_AXIS, AXIS_Z);
    send_vertex(vtx(0, 0, 700, 0, 0, 0));     // on the pole
    send_vertex(vtx(300, -200, 100, 0, 0, 0));
    send_vertex(vtx(-32768, -32768, -32768, 0, 0, 0));
  endtask

  task automatic test_cubic;
    write_reg(REG_KIND, KIND_CUBIC);
    write_reg(REG_ROTATION, {16'h4000, 16'h8000, 16'hC000});   // quarter turns
    send_vertex(vtx(100, 200, 300, 16384, 16384, 16384));      // full tie
    send_vertex(vtx(100, 200, 300, 16384, -16384, 0));         // Y over X
    send_vertex(vtx(100, 200, 300, -16384, 0, 100));           // X dominant
    send_vertex(vtx(-5, 9, 1, -32768, 32767, -32768));
    send_vertex(vtx(-5, 9, 1, 1, -1, 1));
    write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);                 // ignored index
  endtask

  task automatic test_random;
    logic [47:0] inv;
    for (int s = 0; s < RAND_SETS; s++) begin
      // Light sender idling first, then heavy idling, then none.
      if (s < RAND_SETS / 3) send_idle_pct = 34;
      else if (s < 2 * RAND_SETS / 3) send_idle_pct = 56;
      else send_idle_pct = 0;
      write_reg(REG_KIND, 48'(s % 4));
      write_reg(REG_AXIS, 48'($urandom_range(3)));
      write_reg(REG_CENTER, (s == 1) ? 48'h7FFF_8000_7FFF : 48'({$urandom, $urandom}));
      inv = 48'({$urandom, $urandom});
      if (s == 2) inv = 48'hFFFF_FFFF_FFFF;
      if (s == 3) inv = 48'h0;
      write_reg(REG_INV_SCALE, inv);
      write_reg(REG_ROTATION, (s == 5) ? 48'hFFFF_FFFF_FFFF
                              : {rand_angle(), rand_angle(), rand_angle()});
      write_reg(REG_WRAP_W, (s == 6) ? 48'h0 : (s == 5) ? 48'hFFFF : 48'($urandom));
      write_reg(REG_WRAP_H, (s == 6) ? 48'hFFFF : (s == 10) ? 48'h0 : 48'($urandom));
      for (int n = 0; n < RAND_ITEMS; n++) send_vertex(rand_vertex());
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_KIND;
    cfg_data = '0;
    failed = 1'b0;
    mismatches = 0;
    send_idle_pct = 34;
    m_kind = KIND_PLANAR;
    m_axis = AXIS_X;
    m_center = '0;
    m_inv_scale = 48'h0100_0100_0100;
    m_rotation = '0;
    m_wrap_w = 16'h0100;
    m_wrap_h = 16'h0100;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_planar();
    test_cylindrical();
    test_spherical();
    test_cubic();
    test_random();

    drain();
    repeat (20) @(posedge clk);
    if (!failed && pending_uv.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
